>>> sv/tli_pkg.sv
// Package for the two-line intersection unit: widths, payload types and helpers.
// Depends on nothing; used by every module of the block.
package tli_pkg;

    localparam int unsigned COORD_W = 32;
    localparam int unsigned DIFF_W  = 33;
    localparam int unsigned PROD_W  = 66;
    localparam int unsigned DET_W   = 68;
    localparam int unsigned NUM_W   = 104;
    localparam int unsigned DIV_W   = 104;
    localparam int unsigned DIVS_W  = 68;

    typedef enum logic [1:0] {
        CASE_NONE   = 2'd0,
        CASE_A_VERT = 2'd1,
        CASE_B_VERT = 2'd2,
        CASE_GEN    = 2'd3
    } t_case;

    typedef struct packed {
        logic signed [COORD_W-1:0] ax0;
        logic signed [COORD_W-1:0] ay0;
        logic signed [COORD_W-1:0] bx0;
        logic signed [COORD_W-1:0] by0;
        logic signed [DIFF_W-1:0]  dxa;
        logic signed [DIFF_W-1:0]  dya;
        logic signed [DIFF_W-1:0]  dxb;
        logic signed [DIFF_W-1:0]  dyb;
    } t_diff;

    // one division job: result sign with numerator and divisor magnitudes
    typedef struct packed {
        logic                    neg;
        logic [DIV_W-1:0]        num;
        logic [DIVS_W-1:0]       den;
    } t_div_job;

    // saturate a signed wide quotient to 32 bits, with an overflow flag in the top bit
    function automatic logic [COORD_W:0] sat32(input logic signed [NUM_W-1:0] v);
        logic hi_ok;
        hi_ok = (v[NUM_W-1:COORD_W-1] == '0) || (v[NUM_W-1:COORD_W-1] == '1);
        if (hi_ok) begin
            sat32 = {1'b0, v[COORD_W-1:0]};
        end else if (v[NUM_W-1]) begin
            sat32 = {1'b1, 1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            sat32 = {1'b1, 1'b0, {(COORD_W-1){1'b1}}};
        end
    endfunction

endpackage

>>> sv/two_line_intersection_unit.sv
// Two-line intersection unit: top level with front stages, two dividers,
// saturation and output register. Depends on tli_pkg, tli_front, tli_div.
//
// Accepts one line pair per clock unless the output stalls, and returns one
// result per pair in order. Each result passes through four front stages,
// an entry register and 104 quotient stages in each coordinate's pipelined
// divider (one quotient bit per stage), and the output register. The whole
// pipeline advances only while the output register is free or being taken,
// so a stall holds every item in place.
// Parallel, coincident or both-vertical pairs give valid_res 0 and zero fields.
module two_line_intersection_unit #(
    parameter int unsigned COORD_FRAC_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
    input  logic [255:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // cross_x, cross_y
    output logic [63:0]  m_axis_tdata,
    // valid_res, overflow
    output logic [1:0]   m_axis_tuser
);
    localparam int unsigned W = tli_pkg::COORD_W;
    localparam int unsigned TAG_W = 2 + W;

    logic           n_en;
    logic           r_out_v;
    logic [63:0]    r_out;
    logic [1:0]     r_user;
    tli_pkg::t_diff n_diff;
    logic           f_v;
    tli_pkg::t_case f_case;
    logic signed [tli_pkg::NUM_W-1:0] f_xn, f_yn, qx, qy;
    logic signed [tli_pkg::DET_W-1:0] f_den;
    logic signed [W-1:0]              f_xf;
    logic [TAG_W-1:0] tx, ty;
    logic             vx, vy;
    logic [W:0]       n_sx, n_sy;
    logic [W-1:0]     n_x, n_y;
    logic             n_ok, n_ovf;

    // advance when output is empty or being drained
    assign n_en = !r_out_v || m_axis_tready;
    assign s_axis_tready = n_en;

    // unpack and difference the endpoints (fraction point does not move)
    always_comb begin
        n_diff.ax0 = s_axis_tdata[0*W +: W];
        n_diff.ay0 = s_axis_tdata[1*W +: W];
        n_diff.bx0 = s_axis_tdata[4*W +: W];
        n_diff.by0 = s_axis_tdata[5*W +: W];
        n_diff.dxa = tli_pkg::DIFF_W'($signed(s_axis_tdata[2*W +: W]))
                   - tli_pkg::DIFF_W'($signed(s_axis_tdata[0*W +: W]));
        n_diff.dya = tli_pkg::DIFF_W'($signed(s_axis_tdata[3*W +: W]))
                   - tli_pkg::DIFF_W'($signed(s_axis_tdata[1*W +: W]));
        n_diff.dxb = tli_pkg::DIFF_W'($signed(s_axis_tdata[6*W +: W]))
                   - tli_pkg::DIFF_W'($signed(s_axis_tdata[4*W +: W]));
        n_diff.dyb = tli_pkg::DIFF_W'($signed(s_axis_tdata[7*W +: W]))
                   - tli_pkg::DIFF_W'($signed(s_axis_tdata[5*W +: W]));
    end

    tli_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(n_en),
        .i_valid(s_axis_tvalid), .i_diff(n_diff),
        .o_valid(f_v), .o_case(f_case), .o_xnum(f_xn), .o_ynum(f_yn),
        .o_den(f_den), .o_xfix(f_xf)
    );

    tli_div #(.TAG_W(TAG_W)) u_div_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(n_en), .i_valid(f_v),
        .i_tag({f_case, f_xf}), .i_num(f_xn), .i_den(f_den),
        .o_valid(vx), .o_tag(tx), .o_quot(qx)
    );

    tli_div #(.TAG_W(TAG_W)) u_div_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(n_en), .i_valid(f_v),
        .i_tag({f_case, f_xf}), .i_num(f_yn), .i_den(f_den),
        .o_valid(vy), .o_tag(ty), .o_quot(qy)
    );

    // saturate and select per case
    always_comb begin
        n_sx = tli_pkg::sat32(qx);
        n_sy = tli_pkg::sat32(qy);
        n_ok = 1'b1;
        case (tli_pkg::t_case'(tx[TAG_W-1:W]))
            tli_pkg::CASE_A_VERT, tli_pkg::CASE_B_VERT: begin
                n_x   = tx[W-1:0];
                n_y   = n_sy[W-1:0];
                n_ovf = n_sy[W];
            end
            tli_pkg::CASE_GEN: begin
                n_x   = n_sx[W-1:0];
                n_y   = n_sy[W-1:0];
                n_ovf = n_sx[W] | n_sy[W];
            end
            default: begin
                n_x   = '0;
                n_y   = '0;
                n_ovf = 1'b0;
                n_ok  = 1'b0;
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (n_en) begin
            r_out_v <= vx;
        end
        if (n_en) begin
            r_out  <= {n_y, n_x};
            r_user <= {n_ovf, n_ok};
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out;
    assign m_axis_tuser  = r_user;

`ifndef NO_ASSERTIONS
    a_lanes: assert property (@(posedge i_clk) disable iff (!i_rst_n) vx == vy)
        else $error("divider lanes out of step");
    a_tags: assert property (@(posedge i_clk) disable iff (!i_rst_n) vx |-> tx == ty)
        else $error("divider tags differ");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output changed while stalled");
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0 && !m_axis_tuser[1])
        else $error("invalid result not zero");
    a_frac: assert property (@(posedge i_clk) COORD_FRAC_BITS <= 30)
        else $error("fraction bits out of range");
`endif

endmodule

>>> sv/tli_front.sv
// Front stages: coordinate differences, products, determinant and numerators.
// Depends on tli_pkg.
module tli_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  tli_pkg::t_diff                i_diff,
    output logic                          o_valid,
    output tli_pkg::t_case                o_case,
    output logic signed [tli_pkg::NUM_W-1:0]  o_xnum,
    output logic signed [tli_pkg::NUM_W-1:0]  o_ynum,
    output logic signed [tli_pkg::DET_W-1:0]  o_den,
    output logic signed [tli_pkg::COORD_W-1:0] o_xfix
);
    // wide factors are split into a signed high half and an unsigned low half
    localparam int unsigned HALF = tli_pkg::DET_W / 2;

    // stage 1 registers: pairwise products
    logic                               r_v1;
    tli_pkg::t_case                     r_case1;
    logic signed [tli_pkg::PROD_W-1:0]  r_p0, r_p1, r_p2, r_p3;
    logic signed [tli_pkg::COORD_W-1:0] r_ax1, r_ay1, r_bx1;
    logic signed [tli_pkg::DIFF_W-1:0]  r_dxa1, r_dya1, r_dxb1;
    // stage 2 registers: determinant and t
    logic                               r_v2;
    tli_pkg::t_case                     r_case2;
    logic signed [tli_pkg::DET_W-1:0]   r_d2, r_t2;
    logic signed [tli_pkg::COORD_W-1:0] r_ax2, r_ay2, r_bx2;
    logic signed [tli_pkg::DIFF_W-1:0]  r_dxa2, r_dya2;
    // stage 3 registers: half-width partial products
    logic                               r_v3;
    tli_pkg::t_case                     r_case3;
    logic signed [tli_pkg::DET_W-1:0]   r_xah3, r_xal3, r_xbh3, r_xbl3;
    logic signed [tli_pkg::DET_W-1:0]   r_yah3, r_yal3, r_ybh3, r_ybl3;
    logic signed [tli_pkg::DET_W-1:0]   r_d3;
    logic signed [tli_pkg::COORD_W-1:0] r_xf3;
    // stage 4 registers: full numerators
    logic                               r_v4;
    tli_pkg::t_case                     r_case4;
    logic signed [tli_pkg::NUM_W-1:0]   r_xn4, r_yn4;
    logic signed [tli_pkg::DET_W-1:0]   r_d4;
    logic signed [tli_pkg::COORD_W-1:0] r_xf4;

    tli_pkg::t_case                     n_case1;
    logic signed [tli_pkg::DIFF_W-1:0]  n_ea, n_eb;

    // classify the pair and form the offsets
    always_comb begin
        n_ea = tli_pkg::DIFF_W'(i_diff.bx0) - tli_pkg::DIFF_W'(i_diff.ax0);
        n_eb = tli_pkg::DIFF_W'(i_diff.by0) - tli_pkg::DIFF_W'(i_diff.ay0);
        if (i_diff.dxa == '0 && i_diff.dxb != '0) begin
            n_case1 = tli_pkg::CASE_A_VERT;
        end else if (i_diff.dxa != '0 && i_diff.dxb == '0) begin
            n_case1 = tli_pkg::CASE_B_VERT;
        end else if (i_diff.dxa != '0) begin
            n_case1 = tli_pkg::CASE_GEN;
        end else begin
            n_case1 = tli_pkg::CASE_NONE;
        end
    end

    // stage 1: four products, chosen per case
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
        end
        if (i_en) begin
            r_case1 <= n_case1;
            r_ax1   <= i_diff.ax0;
            r_ay1   <= i_diff.ay0;
            r_bx1   <= i_diff.bx0;
            r_dxa1  <= i_diff.dxa;
            r_dya1  <= i_diff.dya;
            r_dxb1  <= i_diff.dxb;
            case (n_case1)
                tli_pkg::CASE_A_VERT: begin
                    r_p0 <= tli_pkg::PROD_W'(i_diff.by0 * i_diff.dxb);
                    r_p1 <= tli_pkg::PROD_W'(i_diff.dyb * (-n_ea));
                    r_p2 <= '0;
                    r_p3 <= '0;
                end
                tli_pkg::CASE_B_VERT: begin
                    r_p0 <= tli_pkg::PROD_W'(i_diff.ay0 * i_diff.dxa);
                    r_p1 <= tli_pkg::PROD_W'(i_diff.dya * n_ea);
                    r_p2 <= '0;
                    r_p3 <= '0;
                end
                default: begin
                    r_p0 <= tli_pkg::PROD_W'(i_diff.dxa * i_diff.dyb);
                    r_p1 <= tli_pkg::PROD_W'(i_diff.dya * i_diff.dxb);
                    r_p2 <= tli_pkg::PROD_W'(n_ea * i_diff.dyb);
                    r_p3 <= tli_pkg::PROD_W'(n_eb * i_diff.dxb);
                end
            endcase
        end
    end

    // stage 2: sum the products; a zero determinant drops the general case
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v2 <= r_v1;
        end
        if (i_en) begin
            r_ax2  <= r_ax1;
            r_ay2  <= r_ay1;
            r_dxa2 <= r_dxa1;
            r_dya2 <= r_dya1;
            case (r_case1)
                tli_pkg::CASE_A_VERT: begin
                    r_case2 <= r_case1;
                    r_t2  <= tli_pkg::DET_W'(r_p0) + tli_pkg::DET_W'(r_p1);
                    r_d2  <= tli_pkg::DET_W'(r_dxb1);
                    r_bx2 <= r_ax1;
                end
                tli_pkg::CASE_B_VERT: begin
                    r_case2 <= r_case1;
                    r_t2  <= tli_pkg::DET_W'(r_p0) + tli_pkg::DET_W'(r_p1);
                    r_d2  <= tli_pkg::DET_W'(r_dxa1);
                    r_bx2 <= r_bx1;
                end
                default: begin
                    r_case2 <= (r_case1 == tli_pkg::CASE_GEN && r_p0 == r_p1)
                             ? tli_pkg::CASE_NONE : r_case1;
                    r_t2  <= tli_pkg::DET_W'(r_p2) - tli_pkg::DET_W'(r_p3);
                    r_d2  <= tli_pkg::DET_W'(r_p0) - tli_pkg::DET_W'(r_p1);
                    r_bx2 <= r_bx1;
                end
            endcase
        end
    end

    // stage 3: start point times D and direction times t, by halves of D and t
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v3 <= r_v2;
        end
        if (i_en) begin
            r_case3 <= r_case2;
            r_d3    <= r_d2;
            r_xf3   <= r_bx2;
            r_xah3  <= tli_pkg::DET_W'(r_ax2 * $signed(r_d2[tli_pkg::DET_W-1:HALF]));
            r_xal3  <= tli_pkg::DET_W'(r_ax2 * $signed({1'b0, r_d2[HALF-1:0]}));
            r_xbh3  <= tli_pkg::DET_W'(r_dxa2 * $signed(r_t2[tli_pkg::DET_W-1:HALF]));
            r_xbl3  <= tli_pkg::DET_W'(r_dxa2 * $signed({1'b0, r_t2[HALF-1:0]}));
            // vertical cases carry the ready y numerator in t
            if (r_case2 inside {tli_pkg::CASE_A_VERT, tli_pkg::CASE_B_VERT}) begin
                r_yah3 <= '0;
                r_yal3 <= r_t2;
                r_ybh3 <= '0;
                r_ybl3 <= '0;
            end else begin
                r_yah3 <= tli_pkg::DET_W'(r_ay2 * $signed(r_d2[tli_pkg::DET_W-1:HALF]));
                r_yal3 <= tli_pkg::DET_W'(r_ay2 * $signed({1'b0, r_d2[HALF-1:0]}));
                r_ybh3 <= tli_pkg::DET_W'(r_dya2 * $signed(r_t2[tli_pkg::DET_W-1:HALF]));
                r_ybl3 <= tli_pkg::DET_W'(r_dya2 * $signed({1'b0, r_t2[HALF-1:0]}));
            end
        end
    end

    // stage 4: recombine the halves into full numerators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v4 <= r_v3;
        end
        if (i_en) begin
            r_case4 <= r_case3;
            r_d4    <= r_d3;
            r_xf4   <= r_xf3;
            r_xn4   <= (tli_pkg::NUM_W'(r_xah3) <<< HALF) + tli_pkg::NUM_W'(r_xal3)
                     + (tli_pkg::NUM_W'(r_xbh3) <<< HALF) + tli_pkg::NUM_W'(r_xbl3);
            r_yn4   <= (tli_pkg::NUM_W'(r_yah3) <<< HALF) + tli_pkg::NUM_W'(r_yal3)
                     + (tli_pkg::NUM_W'(r_ybh3) <<< HALF) + tli_pkg::NUM_W'(r_ybl3);
        end
    end

    // present the last stage
    always_comb begin
        o_valid = r_v4;
        o_case  = r_case4;
        o_den   = r_d4;
        o_xfix  = r_xf4;
        o_xnum  = r_xn4;
        o_ynum  = r_yn4;
    end

endmodule

>>> sv/tli_div.sv
// Pipelined signed restoring divider, one quotient bit per stage.
// Depends on tli_pkg.
module tli_div #(
    parameter int unsigned TAG_W = 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic [TAG_W-1:0]                  i_tag,
    input  logic signed [tli_pkg::NUM_W-1:0]  i_num,
    input  logic signed [tli_pkg::DET_W-1:0]  i_den,
    output logic                              o_valid,
    output logic [TAG_W-1:0]                  o_tag,
    output logic signed [tli_pkg::NUM_W-1:0]  o_quot
);
    localparam int unsigned N = tli_pkg::DIV_W;
    localparam int unsigned R = tli_pkg::DIVS_W + 1;

    logic                   r_v   [N+1];
    logic [TAG_W-1:0]       r_tag [N+1];
    logic                   r_neg [N+1];
    logic [N-1:0]           r_q   [N+1];
    logic [R-1:0]           r_rem [N+1];
    logic [tli_pkg::DIVS_W-1:0] r_den [N+1];

    logic [N-1:0]               n_absn;
    logic [tli_pkg::DIVS_W-1:0] n_absd;

    // take magnitudes at entry
    always_comb begin
        n_absn = i_num[N-1] ? N'(-i_num) : N'(i_num);
        n_absd = i_den[tli_pkg::DET_W-1] ? tli_pkg::DIVS_W'(-i_den)
                                         : tli_pkg::DIVS_W'(i_den);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
        if (i_en) begin
            r_tag[0] <= i_tag;
            r_neg[0] <= i_num[N-1] ^ i_den[tli_pkg::DET_W-1];
            r_q[0]   <= n_absn;
            r_rem[0] <= '0;
            r_den[0] <= (n_absd == '0) ? tli_pkg::DIVS_W'(1) : n_absd;
        end
    end

    // one restoring step per stage; quotient shifts into the numerator
    for (genvar g = 0; g < N; g++) begin : g_step
        logic [R-1:0] n_sh;
        logic [R-1:0] n_df;
        always_comb begin
            n_sh = {r_rem[g][R-2:0], r_q[g][N-1]};
            n_df = n_sh - R'(r_den[g]);
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g+1] <= 1'b0;
            end else if (i_en) begin
                r_v[g+1] <= r_v[g];
            end
            if (i_en) begin
                r_tag[g+1] <= r_tag[g];
                r_neg[g+1] <= r_neg[g];
                r_den[g+1] <= r_den[g];
                r_rem[g+1] <= n_df[R-1] ? n_sh : n_df;
                r_q[g+1]   <= {r_q[g][N-2:0], ~n_df[R-1]};
            end
        end
    end

    assign o_valid = r_v[N];
    assign o_tag   = r_tag[N];
    assign o_quot  = r_neg[N] ? -$signed(r_q[N]) : $signed(r_q[N]);

endmodule
